// File: sv/assert_macros.svh
// Assertion macros shared by the texel expander RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/prgba_pkg.sv
// Types, constants and helper functions of the paletted texel expander.
// Used by every module of the block; depends on nothing.
package prgba_pkg;

   // Pixel modes held in the mode register
   typedef enum logic [1:0] {
      MODE_DIRECT = 2'd0,
      MODE_4BPP   = 2'd1,
      MODE_8BPP   = 2'd2
   } mode_type;

   // Register indexes on the CSR port (byte address / 4)
   localparam logic [1:0] REG_PIXEL_MODE     = 2'd0;
   localparam logic [1:0] REG_INDEX_SWIZZLE  = 2'd1;
   localparam logic [1:0] REG_PALETTE_BYTES  = 2'd2;
   localparam logic [1:0] REG_PALETTE_FORMAT = 2'd3;

   localparam logic [2:0]  PAL_FORMAT_32BIT   = 3'd3;
   localparam logic [10:0] SWZ_MIN_BYTES      = 11'd128;
   localparam logic [7:0]  SWZ_KEEP_MASK      = 8'hE7;
   localparam logic [7:0]  SWZ_BIT3           = 8'h08;
   localparam logic [7:0]  SWZ_BIT4           = 8'h10;
   localparam logic [7:0]  NIBBLE_MASK        = 8'h0F;
   localparam logic [7:0]  ALPHA_MAX          = 8'd255;

   // Per-pixel control carried down the pipeline
   typedef struct packed {
      logic two;     // item yields two results
      logic err;     // unsupported format or mode
      logic direct;  // color comes from the pixel word
      logic lo_oob;  // first index beyond the palette
      logic hi_oob;  // second index beyond the palette
      logic fin;     // last pixel item of the image
   } pix_ctrl_type;

   // CSM1 swizzle: swap index bits 3 and 4
   function automatic logic [7:0] swap_bits34(input logic [7:0] idx);
      logic [7:0] b3;
      logic [7:0] b4;
      b3 = idx & SWZ_BIT3;
      b4 = idx & SWZ_BIT4;
      return (idx & SWZ_KEEP_MASK) | (b3 << 1) | (b4 >> 1);
   endfunction

   // RGB unchanged, alpha doubled with saturation
   function automatic logic [31:0] expand_color(input logic [31:0] c);
      logic [7:0] a;
      a = c[31:24];
      return {(a[7] ? ALPHA_MAX : {a[6:0], 1'b0}), c[23:0]};
   endfunction

endpackage

// File: sv/prgba_decode.sv
// Input stage: registers the accepted item and decodes mode, indices and writes.
// Depends on prgba_pkg.
module prgba_decode
   import prgba_pkg::*;
#(
   parameter int PALETTE_DEPTH = 256,
   parameter int ADDR_W = $clog2(PALETTE_DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic              in_kind,
   input  logic [7:0]        in_slot,
   input  logic [31:0]       in_entry,
   input  logic [31:0]       in_word,
   input  logic              in_low_only,
   input  logic              in_final,
   input  logic [1:0]        cfg_mode,
   input  logic              cfg_swizzle,
   input  logic [10:0]       cfg_bytes,
   input  logic [2:0]        cfg_format,
   input  logic              next_ready,
   output logic              pix_valid,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [31:0]       wr_data,
   output logic [ADDR_W-1:0] rd_addr_lo,
   output logic [ADDR_W-1:0] rd_addr_hi,
   output pix_ctrl_type      ctrl,
   output logic [31:0]       word
);

   localparam logic [8:0] DEPTH_W9 = 9'(PALETTE_DEPTH);

   logic        valid_ff;
   logic        kind_ff;
   logic [7:0]  slot_ff;
   logic [31:0] entry_ff;
   logic [31:0] word_ff;
   logic        low_ff;
   logic        fin_ff;
   logic [7:0]  idx_lo;
   logic [7:0]  idx_hi;
   logic        fmt_ok;
   logic        sw4;

   assign in_ready = !valid_ff || next_ready;

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         kind_ff  <= in_kind;
         slot_ff  <= in_slot;
         entry_ff <= in_entry;
         word_ff  <= in_word;
         low_ff   <= in_low_only;
         fin_ff   <= in_final;
      end
   end

   // Palette write side
   assign wr_en   = valid_ff && !kind_ff && ({1'b0, slot_ff} < DEPTH_W9);
   assign wr_addr = slot_ff[ADDR_W-1:0];
   assign wr_data = entry_ff;

   assign fmt_ok = (cfg_format == PAL_FORMAT_32BIT);
   assign sw4    = cfg_swizzle && (cfg_bytes >= SWZ_MIN_BYTES);

   // Mode decode and index selection
   always_comb begin
      idx_lo      = 8'd0;
      idx_hi      = 8'd0;
      ctrl.two    = 1'b0;
      ctrl.err    = 1'b0;
      ctrl.direct = 1'b0;
      ctrl.fin    = fin_ff;
      case (mode_type'(cfg_mode))
         MODE_DIRECT: begin
            ctrl.direct = 1'b1;
         end
         MODE_8BPP: begin
            idx_lo   = cfg_swizzle ? swap_bits34(word_ff[7:0]) : word_ff[7:0];
            ctrl.err = !fmt_ok;
         end
         MODE_4BPP: begin
            idx_lo   = word_ff[7:0] & NIBBLE_MASK;
            idx_hi   = (word_ff[7:0] >> 4) & NIBBLE_MASK;
            if (sw4) begin
               idx_lo = swap_bits34(idx_lo);
               idx_hi = swap_bits34(idx_hi);
            end
            ctrl.two = !low_ff;
            ctrl.err = !fmt_ok;
         end
         default: begin
            ctrl.err = 1'b1;
         end
      endcase
      ctrl.lo_oob = ({1'b0, idx_lo} >= DEPTH_W9);
      ctrl.hi_oob = ({1'b0, idx_hi} >= DEPTH_W9);
   end

   assign pix_valid  = valid_ff && kind_ff;
   assign rd_addr_lo = idx_lo[ADDR_W-1:0];
   assign rd_addr_hi = idx_hi[ADDR_W-1:0];
   assign word       = word_ff;

endmodule

// File: sv/prgba_palette.sv
// Palette stage: the palette memory, one write port and two registered read ports.
// Depends on prgba_pkg.
module prgba_palette
   import prgba_pkg::*;
#(
   parameter int PALETTE_DEPTH = 256,
   parameter int ADDR_W = $clog2(PALETTE_DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [31:0]       wr_data,
   input  logic [ADDR_W-1:0] rd_addr_lo,
   input  logic [ADDR_W-1:0] rd_addr_hi,
   input  pix_ctrl_type      in_ctrl,
   input  logic [31:0]       in_word,
   input  logic              next_ready,
   output logic              out_valid,
   output logic [31:0]       rd_lo,
   output logic [31:0]       rd_hi,
   output pix_ctrl_type      out_ctrl,
   output logic [31:0]       out_word
);

   logic [31:0]  mem [PALETTE_DEPTH];
   logic         valid_ff;
   logic [31:0]  rd_lo_ff;
   logic [31:0]  rd_hi_ff;
   pix_ctrl_type ctrl_ff;
   logic [31:0]  word_ff;

   assign in_ready = !valid_ff || next_ready;

   // Writes and reads happen as the item leaves the decode stage, keeping order
   always_ff @(posedge clock) begin
      if (in_ready) begin
         if (wr_en) begin
            mem[wr_addr] <= wr_data;
         end
         rd_lo_ff <= mem[rd_addr_lo];
         rd_hi_ff <= mem[rd_addr_hi];
         ctrl_ff  <= in_ctrl;
         word_ff  <= in_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   assign out_valid = valid_ff;
   assign rd_lo     = rd_lo_ff;
   assign rd_hi     = rd_hi_ff;
   assign out_ctrl  = ctrl_ff;
   assign out_word  = word_ff;

endmodule

// File: sv/prgba_emit.sv
// Output stage: builds the RGBA results and sends one or two per pixel item.
// Depends on prgba_pkg and assert_macros.svh.
`include "assert_macros.svh"

module prgba_emit
   import prgba_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [31:0]  rd_lo,
   input  logic [31:0]  rd_hi,
   input  pix_ctrl_type in_ctrl,
   input  logic [31:0]  in_word,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,
   output logic         rsp_tuser,
   output logic         rsp_tlast
);

   logic        valid_ff;
   logic        half_ff;
   logic        two_ff;
   logic        status_ff;
   logic        fin_ff;
   logic [31:0] res0_ff;
   logic [31:0] res1_ff;
   logic [31:0] res0_in;
   logic [31:0] res1_in;
   logic        done;

   // Result colors
   always_comb begin
      if (in_ctrl.err) begin
         res0_in = 32'd0;
         res1_in = 32'd0;
      end else begin
         if (in_ctrl.direct) begin
            res0_in = expand_color(in_word);
         end else if (in_ctrl.lo_oob) begin
            res0_in = 32'd0;
         end else begin
            res0_in = expand_color(rd_lo);
         end
         res1_in = in_ctrl.hi_oob ? 32'd0 : expand_color(rd_hi);
      end
   end

   // Item is done when its final result is taken
   assign done     = valid_ff && rsp_tready && (!two_ff || half_ff);
   assign in_ready = !valid_ff || done;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
         half_ff  <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         half_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         res0_ff   <= res0_in;
         res1_ff   <= res1_in;
         two_ff    <= in_ctrl.two;
         status_ff <= in_ctrl.err;
         fin_ff    <= in_ctrl.fin;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = half_ff ? res1_ff : res0_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = fin_ff && (!two_ff || half_ff);

   `ASSERT_IMPLY(a_half_needs_pair, clock, reset, half_ff, valid_ff && two_ff, "second half without a paired item")
   `ASSERT_IMPLY(a_first_not_last, clock, reset, valid_ff && two_ff && !half_ff, !rsp_tlast, "last flag on first of two results")
   `ASSERT_NEXT(a_pair_continues, clock, reset, rsp_tvalid && rsp_tready && two_ff && !half_ff, rsp_tvalid && half_ff, "second result of a pair lost")

endmodule

// File: sv/paletted_texel_to_rgba.sv
// Top level of the paletted texel expander: CSR registers and the three-stage pipeline.
// Depends on prgba_pkg, prgba_decode, prgba_palette and prgba_emit.
//
// Expands texture items to RGBA8 pixels. An item on req_ is either a palette write
// (req_tuser = 0), which loads one 32-bit palette entry and yields no result, or pixel
// data (req_tuser = 1), expanded according to the pixel_mode register: direct RGBA, or
// 8bpp / 4bpp palette lookups, with alpha doubled and saturated. The pipeline has three
// register stages (decode, palette read, result); an item passes through each in turn
// before its first result is presented. One item is accepted per cycle while the
// output is not stalled; a 4bpp item carrying both nibbles yields two results and
// holds the result stage until both are taken, which stalls the items behind it. The
// palette memory has no clearing pass and is undefined until written. Registers must
// be written only while idle; the block itself does not enforce this.
module paletted_texel_to_rgba
   import prgba_pkg::*;
#(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   // Input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // palette_slot[7:0], palette_entry[39:8],
                                   // pixel_word[71:40], low_nibble_only[72], zero[79:73]
   input  logic        req_tuser,  // kind
   input  logic        req_tlast,  // final_input
   // Result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // red[7:0], green[15:8], blue[23:16], alpha_out[31:24]
   output logic        rsp_tuser,  // status
   output logic        rsp_tlast,  // last_pixel
   // CSR port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int ADDR_W = $clog2(PALETTE_DEPTH);

   logic [1:0]  mode_ff;
   logic        swizzle_ff;
   logic [10:0] bytes_ff;
   logic [2:0]  format_ff;
   logic        csr_wr;

   logic              s1_pix_valid;
   logic              s1_wr_en;
   logic [ADDR_W-1:0] s1_wr_addr;
   logic [31:0]       s1_wr_data;
   logic [ADDR_W-1:0] s1_rd_lo;
   logic [ADDR_W-1:0] s1_rd_hi;
   pix_ctrl_type      s1_ctrl;
   logic [31:0]       s1_word;
   logic              s2_ready;

   logic              s2_valid;
   logic [31:0]       s2_rd_lo;
   logic [31:0]       s2_rd_hi;
   pix_ctrl_type      s2_ctrl;
   logic [31:0]       s2_word;
   logic              s3_ready;

   // CSR registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_DIRECT;
         swizzle_ff <= 1'b0;
         bytes_ff   <= 11'd0;
         format_ff  <= PAL_FORMAT_32BIT;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_PIXEL_MODE:     mode_ff    <= csr_pwdata[1:0];
            REG_INDEX_SWIZZLE:  swizzle_ff <= csr_pwdata[0];
            REG_PALETTE_BYTES:  bytes_ff   <= csr_pwdata[10:0];
            REG_PALETTE_FORMAT: format_ff  <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_PIXEL_MODE:     csr_prdata = {30'd0, mode_ff};
         REG_INDEX_SWIZZLE:  csr_prdata = {31'd0, swizzle_ff};
         REG_PALETTE_BYTES:  csr_prdata = {21'd0, bytes_ff};
         REG_PALETTE_FORMAT: csr_prdata = {29'd0, format_ff};
         default:            csr_prdata = 32'd0;
      endcase
   end

   // Stage 1: decode
   prgba_decode #(
      .PALETTE_DEPTH (PALETTE_DEPTH),
      .ADDR_W        (ADDR_W)
   ) u_decode (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_kind     (req_tuser),
      .in_slot     (req_tdata[7:0]),
      .in_entry    (req_tdata[39:8]),
      .in_word     (req_tdata[71:40]),
      .in_low_only (req_tdata[72]),
      .in_final    (req_tlast),
      .cfg_mode    (mode_ff),
      .cfg_swizzle (swizzle_ff),
      .cfg_bytes   (bytes_ff),
      .cfg_format  (format_ff),
      .next_ready  (s2_ready),
      .pix_valid   (s1_pix_valid),
      .wr_en       (s1_wr_en),
      .wr_addr     (s1_wr_addr),
      .wr_data     (s1_wr_data),
      .rd_addr_lo  (s1_rd_lo),
      .rd_addr_hi  (s1_rd_hi),
      .ctrl        (s1_ctrl),
      .word        (s1_word)
   );

   // Stage 2: palette read
   prgba_palette #(
      .PALETTE_DEPTH (PALETTE_DEPTH),
      .ADDR_W        (ADDR_W)
   ) u_palette (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s1_pix_valid),
      .in_ready   (s2_ready),
      .wr_en      (s1_wr_en),
      .wr_addr    (s1_wr_addr),
      .wr_data    (s1_wr_data),
      .rd_addr_lo (s1_rd_lo),
      .rd_addr_hi (s1_rd_hi),
      .in_ctrl    (s1_ctrl),
      .in_word    (s1_word),
      .next_ready (s3_ready),
      .out_valid  (s2_valid),
      .rd_lo      (s2_rd_lo),
      .rd_hi      (s2_rd_hi),
      .out_ctrl   (s2_ctrl),
      .out_word   (s2_word)
   );

   // Stage 3: results
   prgba_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s2_valid),
      .in_ready   (s3_ready),
      .rd_lo      (s2_rd_lo),
      .rd_hi      (s2_rd_hi),
      .in_ctrl    (s2_ctrl),
      .in_word    (s2_word),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
